>>> sv/sogr_pkg.sv
// ----------------------------------------------------------------------------
// sogr_pkg
// Shared types and constants of the sine oscillator with frequency glide and
// level ramp: payload words, field widths and reset values of the state.
// ----------------------------------------------------------------------------
package sogr_pkg;

  localparam int unsigned FreqInW  = 21;
  localparam int unsigned LevelInW = 15;
  localparam int unsigned LenW     = 7;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned GuardW   = 16;

  localparam int unsigned PhaseW = 32;
  localparam int unsigned FreqW  = FreqInW + GuardW;   // Q24 Hz
  localparam int unsigned LevelW = LevelInW + GuardW;  // Q31 gain
  localparam int unsigned ScaleW = 25;

  localparam logic [LenW-1:0]   MaxBlock   = 7'd64;
  localparam logic [ScaleW-1:0] ScaleReset = 25'd22906492;
  localparam logic [FreqW-1:0]  FreqReset  = 37'd8388608000;  // 500 Hz
  localparam logic [LevelW-1:0] LevelReset = 31'd214748365;   // 0.1

  typedef struct packed {
    logic [FreqInW-1:0]  target_frequency;
    logic [LevelInW-1:0] target_level;
    logic [LenW-1:0]     block_length;
  } sogr_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last;
  } sogr_out_t;

endpackage

>>> sv/sine_oscillator_glide_gain_ramp.sv
// ----------------------------------------------------------------------------
// sine_oscillator_glide_gain_ramp
// Direct digital synthesis sine source: one input word requests a block of
// samples with a linear frequency glide and a linear level ramp.
// ----------------------------------------------------------------------------
//   channel   direction  handshake              payload
//   in        input      in_valid_i/in_ready_o  sogr_in_t  (one block request)
//   out       output     out_valid_o/out_ready_i sogr_out_t (one sample)
//   cfg       input      cfg_we_i, no wait      phase_scale
//
// A block request is accepted and the oscillator state memory is read, the
// bit-serial step divider runs, a set-up state follows and the increment
// pipeline fills; then one sample a cycle follows, but a stall on the output
// holds the whole sample pipeline. Reset leaves the state memory marked
// unwritten, so it reads as the reset state.
// ----------------------------------------------------------------------------
module sine_oscillator_glide_gain_ramp #(
  parameter int unsigned SINE_TABLE_ENTRIES = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  sogr_pkg::sogr_in_t             in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output sogr_pkg::sogr_out_t            out_word_o,
  input  logic                           cfg_we_i,
  input  logic [sogr_pkg::ScaleW-1:0]    cfg_wdata_i
);
  import sogr_pkg::*;

  localparam int unsigned TabW    = SampleW - 1;
  localparam int unsigned IdxW    = $clog2(SINE_TABLE_ENTRIES);
  localparam int unsigned NW      = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int unsigned PosW    = 30 + NW;
  localparam int unsigned DivCntW = $clog2(FreqW + 1);
  localparam int unsigned PpLoW   = PhaseW + ScaleW;
  localparam int unsigned PpHiW   = FreqW - PhaseW + ScaleW;
  localparam int unsigned ProdW   = TabW + LevelW;

  localparam logic [63:0] Q30One    = 64'd1073741824;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] TwoN      = 64'(2 * SINE_TABLE_ENTRIES);
  localparam logic [ProdW:0] RoundHalf = (ProdW + 1)'(1) << (LevelW - 1);

  typedef logic [TabW-1:0] tab_t [SINE_TABLE_ENTRIES];

  // quarter-wave table, fixed-point taylor series evaluated at elaboration
  function automatic tab_t build_tab();
    tab_t        tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] e;
    for (int i = 0; i < SINE_TABLE_ENTRIES; i++) begin
      x  = (HalfPiQ30 * 64'(2 * i + 1)) / TwoN;
      x2 = (x * x) >> 30;
      t  = Q30One;
      t  = Q30One - ((x2 * t) >> 30) / 64'd210;
      t  = Q30One - ((x2 * t) >> 30) / 64'd156;
      t  = Q30One - ((x2 * t) >> 30) / 64'd110;
      t  = Q30One - ((x2 * t) >> 30) / 64'd72;
      t  = Q30One - ((x2 * t) >> 30) / 64'd42;
      t  = Q30One - ((x2 * t) >> 30) / 64'd20;
      t  = Q30One - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      e  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (e > 64'd32767) begin
        e = 64'd32767;
      end
      tab[i] = e[TabW-1:0];
    end
    return tab;
  endfunction

  localparam tab_t SineTab = build_tab();

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StDiv,
    StPrep,
    StRun
  } st_e;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [FreqW-1:0]  freq;
    logic [LevelW-1:0] level;
  } osc_state_t;

  // control
  st_e                 state_q;
  logic [ScaleW-1:0]   phase_scale_q;
  logic                mem_vld_q;
  logic [DivCntW-1:0]  div_cnt_q;
  logic [LenW-1:0]     gen_cnt_q;
  logic [LenW-1:0]     iss_cnt_q;

  // block request
  logic [FreqW-1:0]    tf_q;
  logic [LevelW-1:0]   tl_q;
  logic [LenW-1:0]     len_q;
  logic [LenW-1:0]     len_d;

  // state memory
  osc_state_t          state_mem [1];
  osc_state_t          rd_q;
  osc_state_t          wb_data;
  logic                rd_en;
  logic                wb_en;

  // loaded state and dividers
  logic [PhaseW-1:0]   cur_ph_q;
  logic [FreqW-1:0]    cur_f_q;
  logic [LevelW-1:0]   cur_l_q;
  logic [FreqW-1:0]    ld_f;
  logic [LevelW-1:0]   ld_l;
  logic                ld_fneg;
  logic                ld_lneg;
  logic [FreqW-1:0]    fdvd_q;
  logic [LenW-1:0]     frem_q;
  logic                fneg_q;
  logic [LevelW-1:0]   ldvd_q;
  logic [LenW-1:0]     lrem_q;
  logic                lneg_q;
  logic [LenW:0]       frem_sh;
  logic [LenW:0]       lrem_sh;
  logic                fge;
  logic                lge;
  logic [LenW-1:0]     frem_nx;
  logic [LenW-1:0]     lrem_nx;
  logic signed [FreqW:0]  fstep_q;
  logic signed [LevelW:0] lstep_q;

  // run datapath
  logic                adv;
  logic                gen_fire;
  logic                iss_fire;
  logic                iss_last;
  logic [FreqW-1:0]    f_acc_q;
  logic [FreqW:0]      f_sum;
  logic [FreqW-1:0]    f_q;
  logic                fv_q;
  logic [PpLoW-1:0]    pp_lo_q;
  logic [PpHiW-1:0]    pp_hi_q;
  logic                pv_q;
  logic [PhaseW-1:0]   inc_q;
  logic                iv_q;
  logic [PhaseW-1:0]   phase_q;
  logic [LevelW-1:0]   lev_q;
  logic [LevelW:0]     lev_sum;
  logic [PosW-1:0]     pos_scaled;
  logic [IdxW-1:0]     idx_fold;
  logic [IdxW-1:0]     idx;
  logic [TabW-1:0]     rom_q;
  logic                sneg_q;
  logic                slast_q;
  logic [LevelW-1:0]   slev_q;
  logic                sv_q;
  logic [ProdW-1:0]    prod_q;
  logic                mneg_q;
  logic                mlast_q;
  logic                mv_q;
  logic [ProdW:0]      rnd_sum;
  logic [SampleW-1:0]  rmag;
  logic [SampleW-1:0]  smp;
  logic                out_valid_q;
  sogr_out_t           out_q;

  assign in_ready_o  = (state_q == StIdle);
  assign rd_en       = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // whole sample pipeline moves only when the output register can take a word
  assign adv      = !out_valid_q || out_ready_i;
  assign gen_fire = (state_q == StRun) && adv && (gen_cnt_q != len_q);
  assign iss_fire = adv && iv_q;
  assign iss_last = (iss_cnt_q == LenW'(len_q - 7'd1));
  assign wb_en    = iss_fire && iss_last;

  always_comb begin
    len_d = in_word_i.block_length;
    if (len_d == '0) begin
      len_d = 7'd1;
    end else if (len_d > MaxBlock) begin
      len_d = MaxBlock;
    end
  end

  // state memory: written back at the last sample, read on the next request
  assign wb_data.phase = phase_q + inc_q;
  assign wb_data.freq  = tf_q;
  assign wb_data.level = tl_q;

  always_ff @(posedge clk_i) begin
    if (wb_en) begin
      state_mem[0] <= wb_data;
    end
    if (rd_en) begin
      rd_q <= state_mem[0];
    end
  end

  // unwritten entry reads as the reset state
  always_comb begin
    ld_f    = mem_vld_q ? rd_q.freq  : FreqReset;
    ld_l    = mem_vld_q ? rd_q.level : LevelReset;
    ld_fneg = ld_f > tf_q;
    ld_lneg = ld_l > tl_q;
  end

  // restoring division of the step magnitudes by the block length
  always_comb begin
    frem_sh = {frem_q, fdvd_q[FreqW-1]};
    lrem_sh = {lrem_q, ldvd_q[LevelW-1]};
    fge     = frem_sh >= {1'b0, len_q};
    lge     = lrem_sh >= {1'b0, len_q};
    frem_nx = fge ? LenW'(frem_sh - {1'b0, len_q}) : frem_sh[LenW-1:0];
    lrem_nx = lge ? LenW'(lrem_sh - {1'b0, len_q}) : lrem_sh[LenW-1:0];
  end

  assign f_sum   = (FreqW + 1)'($signed({1'b0, f_acc_q}) + fstep_q);
  assign lev_sum = (LevelW + 1)'($signed({1'b0, lev_q}) + lstep_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      phase_scale_q <= ScaleReset;
      mem_vld_q     <= 1'b0;
      div_cnt_q     <= '0;
      gen_cnt_q     <= '0;
      iss_cnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        phase_scale_q <= cfg_wdata_i;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            tf_q    <= {in_word_i.target_frequency, GuardW'(0)};
            tl_q    <= {in_word_i.target_level, GuardW'(0)};
            len_q   <= len_d;
            state_q <= StLoad;
          end
        end
        StLoad: begin
          cur_ph_q  <= mem_vld_q ? rd_q.phase : '0;
          cur_f_q   <= ld_f;
          cur_l_q   <= ld_l;
          fneg_q    <= ld_fneg;
          lneg_q    <= ld_lneg;
          fdvd_q    <= ld_fneg ? (ld_f - tf_q) : (tf_q - ld_f);
          ldvd_q    <= ld_lneg ? (ld_l - tl_q) : (tl_q - ld_l);
          frem_q    <= '0;
          lrem_q    <= '0;
          div_cnt_q <= '0;
          state_q   <= StDiv;
        end
        StDiv: begin
          fdvd_q <= {fdvd_q[FreqW-2:0], fge};
          frem_q <= frem_nx;
          // level dividend is narrower, so it joins the last LevelW steps
          if (div_cnt_q >= DivCntW'(FreqW - LevelW)) begin
            ldvd_q <= {ldvd_q[LevelW-2:0], lge};
            lrem_q <= lrem_nx;
          end
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == DivCntW'(FreqW - 1)) begin
            state_q <= StPrep;
          end
        end
        StPrep: begin
          fstep_q   <= fneg_q ? -$signed({1'b0, fdvd_q}) : $signed({1'b0, fdvd_q});
          lstep_q   <= lneg_q ? -$signed({1'b0, ldvd_q}) : $signed({1'b0, ldvd_q});
          f_acc_q   <= cur_f_q;
          phase_q   <= cur_ph_q;
          lev_q     <= cur_l_q;
          gen_cnt_q <= '0;
          iss_cnt_q <= '0;
          state_q   <= StRun;
        end
        StRun: begin
          if (gen_fire) begin
            f_acc_q   <= f_sum[FreqW-1:0];
            gen_cnt_q <= gen_cnt_q + 1'b1;
          end
          if (iss_fire) begin
            phase_q   <= phase_q + inc_q;
            lev_q     <= lev_sum[LevelW-1:0];
            iss_cnt_q <= iss_cnt_q + 1'b1;
            if (iss_last) begin
              mem_vld_q <= 1'b1;
              state_q   <= StIdle;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // table address: phase position scaled to the entry count, folded per quadrant
  always_comb begin
    pos_scaled = PosW'(phase_q[29:0]) * PosW'(SINE_TABLE_ENTRIES);
    idx_fold   = pos_scaled[PosW-1:30] < NW'(SINE_TABLE_ENTRIES) ?
                 IdxW'(pos_scaled[PosW-1:30]) : IdxW'(SINE_TABLE_ENTRIES - 1);
    idx        = phase_q[30] ? IdxW'(IdxW'(SINE_TABLE_ENTRIES - 1) - idx_fold) : idx_fold;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q        <= 1'b0;
      pv_q        <= 1'b0;
      iv_q        <= 1'b0;
      sv_q        <= 1'b0;
      mv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      fv_q        <= gen_fire;
      pv_q        <= fv_q;
      iv_q        <= pv_q;
      sv_q        <= iv_q;
      mv_q        <= sv_q;
      out_valid_q <= mv_q;
    end
  end

  always_comb begin
    rnd_sum = {1'b0, prod_q} + RoundHalf;
    rmag    = rnd_sum[ProdW:LevelW];
    if (!mneg_q) begin
      smp = rmag[SampleW-1] ? {1'b0, {(SampleW - 1){1'b1}}} : rmag;
    end else begin
      smp = (rmag > {1'b1, {(SampleW - 1){1'b0}}}) ?
            {1'b1, {(SampleW - 1){1'b0}}} : SampleW'(-rmag);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // frequency for the sample after this one
      f_q     <= f_sum[FreqW-1:0];
      // increment split into two partial products
      pp_lo_q <= PpLoW'(f_q[PhaseW-1:0]) * PpLoW'(phase_scale_q);
      pp_hi_q <= PpHiW'(f_q[FreqW-1:PhaseW]) * PpHiW'(phase_scale_q);
      inc_q   <= PhaseW'(pp_lo_q[PpLoW-1:PhaseW]) + PhaseW'(pp_hi_q);
      rom_q   <= SineTab[idx];
      sneg_q  <= phase_q[31];
      slast_q <= iss_last;
      slev_q  <= lev_q;
      prod_q  <= ProdW'(rom_q) * ProdW'(slev_q);
      mneg_q  <= sneg_q;
      mlast_q <= slast_q;
      if (mv_q) begin
        out_q.sample <= $signed(smp);
        out_q.last   <= mlast_q;
      end
    end
  end

  // nothing in the increment pipeline when a new request can be taken
  a_idle_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!fv_q && !pv_q && !iv_q))
    else $error("request taken while increment pipeline busy");

  // serial division leaves remainders below the divisor
  a_div_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPrep) |-> (frem_q < len_q) && (lrem_q < len_q))
    else $error("divider remainder out of range");

  // every frequency of the block was generated before state write-back
  a_wb_all_gen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_en |-> (gen_cnt_q == len_q) && !fv_q && !pv_q)
    else $error("write-back before block fully generated");

  // samples are issued only inside a running block
  a_issue_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    iv_q |-> (state_q == StRun) && (iss_cnt_q < len_q))
    else $error("sample issued outside a block");

  // level below one keeps the rounded magnitude below full scale
  a_no_neg_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.sample != {1'b1, {(SampleW - 1){1'b0}}}))
    else $error("sample reached negative full scale");

endmodule
